/* hw/rtl/cfsp_pkg.sv */
// Package with the shared types, codes and layout table of the format string parser.
package cfsp_pkg;

	localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_MALFORM  = 2'd1;
	localparam logic [1:0] ST_TRAILING = 2'd2;
	localparam logic [1:0] ST_BAD_DEC  = 2'd3;

	localparam logic [5:0] TY_NA        = 6'd0;
	localparam logic [5:0] TY_BOOL      = 6'd1;
	localparam logic [5:0] TY_INT8      = 6'd2;
	localparam logic [5:0] TY_UINT8     = 6'd3;
	localparam logic [5:0] TY_INT16     = 6'd4;
	localparam logic [5:0] TY_UINT16    = 6'd5;
	localparam logic [5:0] TY_INT32     = 6'd6;
	localparam logic [5:0] TY_UINT32    = 6'd7;
	localparam logic [5:0] TY_INT64     = 6'd8;
	localparam logic [5:0] TY_UINT64    = 6'd9;
	localparam logic [5:0] TY_HALF      = 6'd10;
	localparam logic [5:0] TY_FLOAT     = 6'd11;
	localparam logic [5:0] TY_DOUBLE    = 6'd12;
	localparam logic [5:0] TY_DEC128    = 6'd13;
	localparam logic [5:0] TY_DEC256    = 6'd14;
	localparam logic [5:0] TY_FSB       = 6'd15;
	localparam logic [5:0] TY_BINARY    = 6'd16;
	localparam logic [5:0] TY_STRING    = 6'd17;
	localparam logic [5:0] TY_LBINARY   = 6'd18;
	localparam logic [5:0] TY_LSTRING   = 6'd19;
	localparam logic [5:0] TY_LIST      = 6'd20;
	localparam logic [5:0] TY_LLIST     = 6'd21;
	localparam logic [5:0] TY_FSL       = 6'd22;
	localparam logic [5:0] TY_STRUCT    = 6'd23;
	localparam logic [5:0] TY_MAP       = 6'd24;
	localparam logic [5:0] TY_DENSE     = 6'd25;
	localparam logic [5:0] TY_SPARSE    = 6'd26;
	localparam logic [5:0] TY_DATE32    = 6'd27;
	localparam logic [5:0] TY_DATE64    = 6'd28;
	localparam logic [5:0] TY_TIME32    = 6'd29;
	localparam logic [5:0] TY_TIME64    = 6'd30;
	localparam logic [5:0] TY_TIMESTAMP = 6'd31;
	localparam logic [5:0] TY_DURATION  = 6'd32;
	localparam logic [5:0] TY_IV_MONTH  = 6'd33;
	localparam logic [5:0] TY_IV_DT     = 6'd34;
	localparam logic [5:0] TY_IV_MDN    = 6'd35;
	localparam logic [5:0] TY_DICT      = 6'd36;

	localparam logic [9:0] RL_NONE  = 10'h3FF;
	localparam logic [9:0] RL_PRIM  = {2'd3, 2'd1, 2'd3, 2'd3, 2'd0};
	localparam logic [9:0] RL_VAR   = {2'd3, 2'd2, 2'd3, 2'd1, 2'd0};
	localparam logic [9:0] RL_LVAR  = {2'd3, 2'd2, 2'd1, 2'd3, 2'd0};
	localparam logic [9:0] RL_LIST  = {2'd3, 2'd3, 2'd3, 2'd1, 2'd0};
	localparam logic [9:0] RL_LLIST = {2'd3, 2'd3, 2'd1, 2'd3, 2'd0};
	localparam logic [9:0] RL_VALID = {2'd3, 2'd3, 2'd3, 2'd3, 2'd0};
	localparam logic [9:0] RL_DENSE = {2'd0, 2'd3, 2'd3, 2'd1, 2'd3};
	localparam logic [9:0] RL_SPARS = {2'd0, 2'd3, 2'd3, 2'd3, 2'd3};

	typedef enum logic [4:0] {
		PH_START, PH_DONE, PH_ERR, PH_D_COLON, PH_D_PREC, PH_D_SCALE, PH_D_WIDTH,
		PH_W_COLON, PH_W_NUM, PH_PLUS, PH_PW_COLON, PH_PU, PH_PU_COLON, PH_SUFFIX,
		PH_T, PH_TD, PH_TT, PH_TS, PH_TS_COLON, PH_TDUR, PH_TI
	} phase_t;

	typedef struct packed {
		logic [5:0] storage;
		logic [1:0] nbuf;
		logic [9:0] roles;
	} layout_t;

	function automatic layout_t layout_of(input logic [5:0] ty);
		layout_t l;
		l = '{storage: ty, nbuf: 2'd2, roles: RL_PRIM};
		unique case (ty)
			TY_NA: l = '{storage: TY_NA, nbuf: 2'd0, roles: RL_NONE};
			TY_BINARY, TY_STRING: l = '{storage: ty, nbuf: 2'd3, roles: RL_VAR};
			TY_LBINARY, TY_LSTRING: l = '{storage: ty, nbuf: 2'd3, roles: RL_LVAR};
			TY_LIST: l = '{storage: ty, nbuf: 2'd2, roles: RL_LIST};
			TY_LLIST: l = '{storage: ty, nbuf: 2'd2, roles: RL_LLIST};
			TY_FSL, TY_STRUCT, TY_MAP: l = '{storage: ty, nbuf: 2'd1, roles: RL_VALID};
			TY_DENSE: l = '{storage: ty, nbuf: 2'd2, roles: RL_DENSE};
			TY_SPARSE: l = '{storage: ty, nbuf: 2'd1, roles: RL_SPARS};
			TY_DATE32, TY_TIME32, TY_DURATION: l.storage = TY_INT32;
			TY_DATE64, TY_TIME64, TY_TIMESTAMP: l.storage = TY_INT64;
			default: l = '{storage: ty, nbuf: 2'd2, roles: RL_PRIM};
		endcase
		return l;
	endfunction

	// Time unit letter to code; 4 marks a letter that is no unit.
	function automatic logic [2:0] unit_code(input logic [7:0] c);
		logic [2:0] u;
		u = 3'd4;
		if (c == "s") u = 3'd0;
		else if (c == "m") u = 3'd1;
		else if (c == "u") u = 3'd2;
		else if (c == "n") u = 3'd3;
		return u;
	endfunction

endpackage

/* hw/rtl/cfsp_in_if.sv */
// Input channel carrying one format string byte per transfer.
interface cfsp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] format_byte;
	logic       is_last;
	logic       has_dictionary;

	modport source(output valid, format_byte, is_last, has_dictionary, input ready);
	modport sink(input valid, format_byte, is_last, has_dictionary, output ready);
endinterface

/* hw/rtl/cfsp_out_if.sv */
// Result channel carrying one decoded type description per transfer.
interface cfsp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [5:0]  storage_type;
	logic [5:0]  logical_type;
	logic [1:0]  buffer_count;
	logic [9:0]  buffer_roles;
	logic [1:0]  temporal_unit;
	logic [30:0] first_number;
	logic [30:0] second_number;
	logic [8:0]  suffix_start;
	logic [8:0]  suffix_length;

	modport source(output valid, status, storage_type, logical_type, buffer_count,
		buffer_roles, temporal_unit, first_number, second_number, suffix_start,
		suffix_length, input ready);
	modport sink(input valid, status, storage_type, logical_type, buffer_count,
		buffer_roles, temporal_unit, first_number, second_number, suffix_start,
		suffix_length, output ready);
endinterface

/* hw/rtl/columnar_format_string_parser_unit.sv */
// Columnar type format string parser: one byte per transfer, one result per string.
// Bytes enter an input register and one byte is parsed per cycle, so the next string may
// follow at once; a result is registered when its last byte is parsed and waits in the
// output register while parsing goes on; a last byte waits while that result is untaken.
// Throughput is one byte per cycle unless stalled, limited by the single parse-state update.
// Bytes beyond MAX_FORMAT_LEN in one string are not parsed and give a malformed status.
module columnar_format_string_parser_unit #(
	parameter int MAX_FORMAT_LEN = 256
) (
	input logic clk,
	input logic arst_n,
	cfsp_in_if.sink in_ch,
	cfsp_out_if.source out_ch
);
	import cfsp_pkg::*;

	localparam int BW = $clog2(MAX_FORMAT_LEN + 1);
	localparam int SW = (BW > 9) ? BW : 9;

	logic       valid_s1, last_s1, dict_s1;
	logic [7:0] byte_s1;
	logic       adv;

	phase_t      phase_q;
	logic [BW-1:0] bp_q;
	logic [30:0] acc_q, prec_q, scale_q;
	logic        dseen_q;
	logic [1:0]  err_q, unit_q;
	logic [5:0]  dtype_q;

	phase_t      ph;
	logic [BW-1:0] bp;
	logic [30:0] acc, prec, scl;
	logic        dseen;
	logic [1:0]  err, dun;
	logic [5:0]  dty;
	logic [2:0]  u;
	logic        isdig;
	logic [34:0] acc_mul;
	logic [30:0] acc_dig;

	logic [1:0]  r_status;
	logic [5:0]  r_st, r_lt, ty;
	layout_t     lay;
	logic [30:0] r_fn, r_sn;
	logic [8:0]  r_ss, r_sl;
	logic [SW-1:0] bpx;

	logic        out_valid_q;

	assign adv = !last_s1 || !out_valid_q || out_ch.ready;
	assign in_ch.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.format_byte;
			last_s1 <= in_ch.is_last;
			dict_s1 <= in_ch.has_dictionary;
		end
	end

	assign isdig   = (byte_s1 >= "0") && (byte_s1 <= "9");
	assign acc_mul = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + 35'(byte_s1 - "0");
	assign acc_dig = (acc_mul > 35'(NUM_MAX)) ? NUM_MAX : acc_mul[30:0];
	assign u       = unit_code(byte_s1);

	always_comb begin
		ph = phase_q; bp = bp_q; acc = acc_q; prec = prec_q; scl = scale_q;
		dseen = dseen_q; err = err_q; dty = dtype_q; dun = unit_q;
		if (bp_q >= BW'(MAX_FORMAT_LEN)) begin
			err = ST_MALFORM; ph = PH_ERR;
		end else begin
			bp = bp_q + BW'(1);
			unique case (phase_q)
				PH_START: begin
					ph = PH_DONE;
					priority if (byte_s1 == "n") dty = TY_NA;
					else if (byte_s1 == "b") dty = TY_BOOL;
					else if (byte_s1 == "c") dty = TY_INT8;
					else if (byte_s1 == "C") dty = TY_UINT8;
					else if (byte_s1 == "s") dty = TY_INT16;
					else if (byte_s1 == "S") dty = TY_UINT16;
					else if (byte_s1 == "i") dty = TY_INT32;
					else if (byte_s1 == "I") dty = TY_UINT32;
					else if (byte_s1 == "l") dty = TY_INT64;
					else if (byte_s1 == "L") dty = TY_UINT64;
					else if (byte_s1 == "e") dty = TY_HALF;
					else if (byte_s1 == "f") dty = TY_FLOAT;
					else if (byte_s1 == "g") dty = TY_DOUBLE;
					else if (byte_s1 == "z") dty = TY_BINARY;
					else if (byte_s1 == "u") dty = TY_STRING;
					else if (byte_s1 == "Z") dty = TY_LBINARY;
					else if (byte_s1 == "U") dty = TY_LSTRING;
					else if (byte_s1 == "d") ph = PH_D_COLON;
					else if (byte_s1 == "w") ph = PH_W_COLON;
					else if (byte_s1 == "+") ph = PH_PLUS;
					else if (byte_s1 == "t") ph = PH_T;
					else begin err = ST_MALFORM; ph = PH_ERR; end
				end
				PH_DONE: if (err_q == ST_OK) err = ST_TRAILING;
				PH_D_COLON: begin
					if (byte_s1 == ":") begin
						acc = '0; dseen = 1'b0; ph = PH_D_PREC;
					end else begin err = ST_MALFORM; ph = PH_ERR; end
				end
				PH_D_PREC: begin
					if (isdig) begin
						acc = acc_dig; dseen = 1'b1;
					end else if (byte_s1 == "," && dseen_q) begin
						prec = acc_q; acc = '0; dseen = 1'b0; ph = PH_D_SCALE;
					end else begin err = ST_MALFORM; ph = PH_ERR; end
				end
				PH_D_SCALE: begin
					if (isdig) begin
						acc = acc_dig; dseen = 1'b1;
					end else if (!dseen_q) begin
						err = ST_MALFORM; ph = PH_ERR;
					end else begin
						scl = acc_q; dty = TY_DEC128;
						if (byte_s1 == ",") begin
							acc = '0; dseen = 1'b0; ph = PH_D_WIDTH;
						end else begin
							acc = 31'd128; ph = PH_DONE;
							if (err_q == ST_OK) err = ST_TRAILING;
						end
					end
				end
				PH_D_WIDTH: begin
					if (isdig) begin
						acc = acc_dig; dseen = 1'b1;
					end else if (dseen_q) begin
						ph = PH_DONE;
						if (err_q == ST_OK) err = ST_TRAILING;
					end else begin err = ST_MALFORM; ph = PH_ERR; end
				end
				PH_W_COLON, PH_PW_COLON: begin
					if (byte_s1 == ":") begin
						dty = (phase_q == PH_W_COLON) ? TY_FSB : TY_FSL;
						acc = '0; dseen = 1'b0; ph = PH_W_NUM;
					end else begin err = ST_MALFORM; ph = PH_ERR; end
				end
				PH_W_NUM: begin
					if (isdig) begin
						acc = acc_dig; dseen = 1'b1;
					end else begin
						ph = PH_DONE;
						if (err_q == ST_OK) err = ST_TRAILING;
					end
				end
				PH_PLUS: begin
					ph = PH_DONE;
					priority if (byte_s1 == "l") dty = TY_LIST;
					else if (byte_s1 == "L") dty = TY_LLIST;
					else if (byte_s1 == "s") dty = TY_STRUCT;
					else if (byte_s1 == "m") dty = TY_MAP;
					else if (byte_s1 == "w") ph = PH_PW_COLON;
					else if (byte_s1 == "u") ph = PH_PU;
					else begin err = ST_MALFORM; ph = PH_ERR; end
				end
				PH_PU: begin
					if (byte_s1 == "d") begin
						dty = TY_DENSE; ph = PH_PU_COLON;
					end else if (byte_s1 == "s") begin
						dty = TY_SPARSE; ph = PH_PU_COLON;
					end else begin err = ST_MALFORM; ph = PH_ERR; end
				end
				PH_PU_COLON, PH_TS_COLON: begin
					if (byte_s1 == ":") ph = PH_SUFFIX;
					else begin err = ST_MALFORM; ph = PH_ERR; end
				end
				PH_SUFFIX: ;
				PH_T: begin
					priority if (byte_s1 == "d") ph = PH_TD;
					else if (byte_s1 == "t") ph = PH_TT;
					else if (byte_s1 == "s") ph = PH_TS;
					else if (byte_s1 == "D") ph = PH_TDUR;
					else if (byte_s1 == "i") ph = PH_TI;
					else begin err = ST_MALFORM; ph = PH_ERR; end
				end
				PH_TD: begin
					ph = PH_DONE;
					if (byte_s1 == "D") dty = TY_DATE32;
					else if (byte_s1 == "m") dty = TY_DATE64;
					else begin err = ST_MALFORM; ph = PH_ERR; end
				end
				PH_TT, PH_TS, PH_TDUR: begin
					if (u > 3'd3) begin
						err = ST_MALFORM; ph = PH_ERR;
					end else begin
						dun = u[1:0];
						ph = (phase_q == PH_TS) ? PH_TS_COLON : PH_DONE;
						if (phase_q == PH_TS) dty = TY_TIMESTAMP;
						else if (phase_q == PH_TDUR) dty = TY_DURATION;
						else dty = (u < 3'd2) ? TY_TIME32 : TY_TIME64;
					end
				end
				PH_TI: begin
					ph = PH_DONE;
					if (byte_s1 == "M") dty = TY_IV_MONTH;
					else if (byte_s1 == "D") dty = TY_IV_DT;
					else if (byte_s1 == "n") dty = TY_IV_MDN;
					else begin err = ST_MALFORM; ph = PH_ERR; end
				end
				default: begin err = ST_MALFORM; ph = PH_ERR; end
			endcase
		end

		// End of string: a pending number or keyword must be complete here.
		if (last_s1) begin
			unique case (ph)
				PH_DONE, PH_SUFFIX: ;
				PH_D_SCALE: begin
					if (dseen) begin
						scl = acc; acc = 31'd128; dty = TY_DEC128;
					end else err = ST_MALFORM;
				end
				PH_D_WIDTH, PH_W_NUM: if (!dseen) err = ST_MALFORM;
				default: err = ST_MALFORM;
			endcase
		end

		ty = dty;
		r_status = err;
		if (err != ST_MALFORM && dty == TY_DEC128) begin
			if (acc == 31'd256) ty = TY_DEC256;
			else if (acc != 31'd128) r_status = ST_BAD_DEC;
		end
		lay = layout_of(ty);
		bpx = SW'(bp);
		r_st = '0; r_lt = '0; r_fn = '0; r_sn = '0; r_ss = '0; r_sl = '0;
		if (r_status == ST_OK) begin
			r_st = (ty == TY_DURATION && dun >= 2'd2) ? TY_INT64 : lay.storage;
			r_lt = dict_s1 ? TY_DICT : ty;
			if (ty == TY_DEC128 || ty == TY_DEC256) begin
				r_fn = prec; r_sn = scl;
			end
			if (ty == TY_FSB || ty == TY_FSL) r_fn = acc;
			if (ty == TY_TIMESTAMP || ty == TY_DENSE || ty == TY_SPARSE) begin
				r_ss = 9'd4;
				r_sl = (bpx >= SW'(4)) ? 9'(bpx - SW'(4)) : 9'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START; bp_q <= '0; acc_q <= '0; prec_q <= '0; scale_q <= '0;
			dseen_q <= 1'b0; err_q <= '0; dtype_q <= '0; unit_q <= '0;
		end else if (valid_s1 && adv) begin
			if (last_s1) begin
				phase_q <= PH_START; bp_q <= '0; acc_q <= '0; prec_q <= '0; scale_q <= '0;
				dseen_q <= 1'b0; err_q <= '0; dtype_q <= '0; unit_q <= '0;
			end else begin
				phase_q <= ph; bp_q <= bp; acc_q <= acc; prec_q <= prec; scale_q <= scl;
				dseen_q <= dseen; err_q <= err; dtype_q <= dty; unit_q <= dun;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && last_s1 && adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && last_s1 && adv) begin
			out_ch.status        <= r_status;
			out_ch.storage_type  <= r_st;
			out_ch.logical_type  <= r_lt;
			out_ch.buffer_count  <= (r_status == ST_OK) ? lay.nbuf : 2'd0;
			out_ch.buffer_roles  <= (r_status == ST_OK) ? lay.roles : 10'd0;
			out_ch.temporal_unit <= (r_status == ST_OK) ? dun : 2'd0;
			out_ch.first_number  <= r_fn;
			out_ch.second_number <= r_sn;
			out_ch.suffix_start  <= r_ss;
			out_ch.suffix_length <= r_sl;
		end
	end

	assign out_ch.valid = out_valid_q;

`ifndef SYNTHESIS
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && last_s1))
		else $error("result appeared without a last byte");
	a_error_clears_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_ch.status != ST_OK) |->
		(out_ch.storage_type == '0 && out_ch.first_number == '0 && out_ch.suffix_length == '0))
		else $error("error result carries nonzero fields");
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ch.ready)
		else $error("input stalled with empty input register");
	a_position_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bp_q <= BW'(MAX_FORMAT_LEN))
		else $error("byte position beyond maximum length");
`endif

endmodule
